// ===== rtl/sc1kbd_pkg.sv =====
package sc1kbd_pkg;

    // Prefix and sequence bytes of scan set 1
    localparam logic [7:0] BYTE_EXT   = 8'hE0;
    localparam logic [7:0] BYTE_PAUSE = 8'hE1;
    localparam logic [7:0] EXT_FLAG   = 8'h80;
    localparam logic [7:0] CODE_MASK  = 8'h7F;

    // Pause sequence E1 1D 45 E1 9D C5
    localparam logic [2:0] PAUSE_LEN       = 3'd6;
    localparam logic [2:0] PAUSE_LAST_POS  = 3'd5;
    localparam logic [7:0] PAUSE_SCAN_CODE = 8'hC5;
    localparam logic [6:0] PAUSE_KEYCODE   = 7'd119;
    localparam logic [6:0] KEY_NONE        = 7'd0;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [2:0] pause_pos;
        logic       ext_pending;
    } sc1kbd_state_t;

    // One key event
    typedef struct packed {
        logic       self_release;
        logic       is_press;
        logic [6:0] key_code;
        logic [7:0] scan_code;
    } sc1kbd_evt_t;

    // Expected byte at each position of the Pause sequence
    function automatic logic [7:0] pause_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'hE1;
            3'd1:    b = 8'h1D;
            3'd2:    b = 8'h45;
            3'd3:    b = 8'hE1;
            3'd4:    b = 8'h9D;
            3'd5:    b = 8'hC5;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sc1kbd_keymap.sv =====
module sc1kbd_keymap
    import sc1kbd_pkg::*;
(
    input  logic [7:0] scan_code,
    output logic [6:0] key_code   // KEY_NONE when unmapped
);

    // Map scan code to keycode; plain codes pass through, extended ones use a table
    always_comb begin
        key_code = KEY_NONE;
        if ((scan_code inside {[8'h01:8'h53]}) || (scan_code inside {[8'h56:8'h58]})) begin
            key_code = scan_code[6:0];
        end else begin
            case (scan_code)
                8'h9C:   key_code = 7'd96;
                8'h9D:   key_code = 7'd97;
                8'hB5:   key_code = 7'd98;
                8'hB7:   key_code = 7'd99;
                8'hB8:   key_code = 7'd100;
                8'hC7:   key_code = 7'd102;
                8'hC8:   key_code = 7'd103;
                8'hC9:   key_code = 7'd104;
                8'hCB:   key_code = 7'd105;
                8'hCD:   key_code = 7'd106;
                8'hCF:   key_code = 7'd107;
                8'hD0:   key_code = 7'd108;
                8'hD1:   key_code = 7'd109;
                8'hD2:   key_code = 7'd110;
                8'hD3:   key_code = 7'd111;
                8'hDB:   key_code = 7'd125;
                8'hDC:   key_code = 7'd126;
                8'hDD:   key_code = 7'd127;
                8'hC5:   key_code = PAUSE_KEYCODE;
                default: key_code = KEY_NONE;
            endcase
        end
    end

endmodule

// ===== rtl/sc1kbd_decode.sv =====
module sc1kbd_decode
    import sc1kbd_pkg::*;
(
    input  logic [7:0]    scan_byte,
    input  sc1kbd_state_t state_cur,
    output sc1kbd_state_t state_nxt,
    output logic          evt_valid,
    output sc1kbd_evt_t   evt
);

    logic [7:0] code;
    logic [6:0] key;
    logic       pause_hit;

    // Build scan code from low bits plus extended mark
    assign code = (scan_byte & CODE_MASK) | (state_cur.ext_pending ? EXT_FLAG : 8'h00);

    sc1kbd_keymap u_keymap (
        .scan_code (code),
        .key_code  (key)
    );

    // Byte continues an ongoing Pause match
    assign pause_hit = (state_cur.pause_pos != 3'd0) && (state_cur.pause_pos < PAUSE_LEN)
                     && (scan_byte == pause_byte(state_cur.pause_pos));

    // Advance Pause match, else handle byte as a fresh one
    always_comb begin
        state_nxt = state_cur;
        evt_valid = 1'b0;
        evt       = '{self_release: 1'b0, is_press: ~scan_byte[7], key_code: key,
                      scan_code: code};
        if (pause_hit) begin
            if (state_cur.pause_pos == PAUSE_LAST_POS) begin
                state_nxt.pause_pos = 3'd0;
                evt_valid = 1'b1;
                evt = '{self_release: 1'b1, is_press: 1'b1, key_code: PAUSE_KEYCODE,
                        scan_code: PAUSE_SCAN_CODE};
            end else begin
                state_nxt.pause_pos = state_cur.pause_pos + 3'd1;
            end
        end else if (scan_byte == BYTE_PAUSE) begin
            state_nxt.pause_pos   = 3'd1;
            state_nxt.ext_pending = 1'b0;
        end else if (scan_byte == BYTE_EXT) begin
            state_nxt.pause_pos   = 3'd0;
            state_nxt.ext_pending = 1'b1;
        end else begin
            state_nxt.pause_pos   = 3'd0;
            state_nxt.ext_pending = 1'b0;
            evt_valid = (key != KEY_NONE);
        end
    end

endmodule

// ===== rtl/scan_set1_keyboard_decoder.sv =====
// Channel | Dir | Beat payload
// s_axis  | in  | tdata[7:0] scan_byte
// m_axis  | out | tdata[7:0] scan_code, [14:8] key_code, [15] is_press,
//         |     | [16] self_release, [23:17] zero
//
// One byte per cycle sustained while m_tready is high; m_tvalid rises once the byte's beat
// has passed the input register, then the result register after decode and key lookup.
// Bytes that give no event are absorbed without using the result register.
// aresetn (synchronous) clears both valid flags and the prefix/Pause state.
// A stalled m_tready holds the result; bytes without an event still pass, but a
// byte with an event waits in the input register and drops s_tready meanwhile.
module scan_set1_keyboard_decoder
    import sc1kbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] scan_code, [14:8] key_code, [15] is_press,
                                   // [16] self_release, [23:17] zero
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg, in_byte_next;
    sc1kbd_state_t state_reg, state_next;
    logic          out_valid_reg, out_valid_next;
    sc1kbd_evt_t   out_evt_reg, out_evt_next;

    sc1kbd_state_t dec_state;
    logic          dec_valid;
    sc1kbd_evt_t   dec_evt;
    logic          out_free;
    logic          advance;

    sc1kbd_decode u_decode (
        .scan_byte (in_byte_reg),
        .state_cur (state_reg),
        .state_nxt (dec_state),
        .evt_valid (dec_valid),
        .evt       (dec_evt)
    );

    // Retire the held byte when its event (if any) has room
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!dec_valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Next-state logic for input register, decoder state and result register
    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_evt_next   = out_evt_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            state_next    = dec_state;
            in_valid_next = 1'b0;
            if (dec_valid) begin
                out_valid_next = 1'b1;
                out_evt_next   = dec_evt;
            end
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        in_byte_reg <= in_byte_next;
        out_evt_reg <= out_evt_next;
    end

    // Drive result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_evt_reg.self_release, out_evt_reg.is_press,
                       out_evt_reg.key_code, out_evt_reg.scan_code};

    // Pause position never runs past the last sequence byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pause_pos <= PAUSE_LAST_POS)
        else $error("pause position out of range");

    // Every emitted beat carries a mapped keycode
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_evt_reg.key_code != KEY_NONE))
        else $error("event with unmapped keycode");

    // Self-release only on the Pause event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_evt_reg.self_release) |->
            (out_evt_reg.key_code == PAUSE_KEYCODE && out_evt_reg.scan_code == PAUSE_SCAN_CODE
             && out_evt_reg.is_press))
        else $error("self-release on non-Pause event");

    // An E0 byte outside a Pause match sets the extended mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_byte_reg == BYTE_EXT && state_reg.pause_pos == 3'd0)
            |=> state_reg.ext_pending)
        else $error("extended prefix lost");

endmodule
